@@ sv/pcrl_pkg.sv @@
// shared types and constants for the per-category rate limiter
package pcrl_pkg;

    localparam int KEY_W        = 32;
    localparam int LIMIT_W      = 16;
    localparam int TIME_W       = 48;
    localparam int WINDOW_W     = 32;
    localparam int NUM_BUCKETS_DEFAULT = 8;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET_US = 32'd1000000;

    typedef struct packed {
        logic [TIME_W-1:0]  window_start;
        logic [LIMIT_W-1:0] count;
    } bucket_t;

endpackage

@@ sv/per_category_rate_limiter_unit.sv @@
// top level of the per-category fixed-window rate limiter
// a request that hits bucket i scans the key ram entries 0 to i, then reads, updates and writes
//   back its record; a new or rejected-for-full key finishes once every used entry is scanned
// one request at a time, busy until it finishes; the time each takes is set by the
//   one-key-per-cycle scan of the key ram and the read-modify-write of the bucket ram
// reset: no buckets claimed, window length 1000000 us; rams are not cleared
// done is a one-cycle strobe; the receiver cannot stall it
module per_category_rate_limiter_unit
    import pcrl_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [WINDOW_W-1:0] cfg_wr_data,
    // request
    input  logic                start,
    output logic                busy,
    input  logic [KEY_W-1:0]    category_key,
    input  logic [LIMIT_W-1:0]  limit,
    input  logic [TIME_W-1:0]   now_us,
    // result
    output logic                done,
    output logic                allowed,
    output logic                table_full
);

    localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W = $clog2(NUM_BUCKETS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [WINDOW_W-1:0] window_reg;
    logic                done_reg, done_next;
    logic                allowed_reg, allowed_next;
    logic                full_reg, full_next;

    // latched request
    logic [KEY_W-1:0]    key_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [TIME_W-1:0]   now_reg;

    // key ram
    logic                key_rd_en;
    logic [IDX_W-1:0]    key_rd_addr;
    logic [KEY_W-1:0]    key_rd_data;
    logic                key_wr_en;

    // bucket ram
    logic                bkt_rd_en;
    logic                bkt_wr_en;
    logic [IDX_W-1:0]    bkt_wr_addr;
    bucket_t             bkt_rd_data;
    bucket_t             upd_in;
    bucket_t             upd_out;
    logic                upd_allowed;

    // scan helpers
    logic                accept;
    logic                match;
    logic [CNT_W:0]      next_pos;
    logic                is_last;
    logic                all_used;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign allowed  = allowed_reg;
    assign table_full = full_reg;

    // key stored per bucket, scanned one entry per cycle
    pcrl_ram #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (KEY_W),
        .AW    (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (IDX_W'(used_reg)),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    // window start and count per bucket, read-modify-write on a hit, written directly on a claim
    pcrl_ram #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH ($bits(bucket_t)),
        .AW    (IDX_W)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (bkt_wr_en),
        .wr_addr (bkt_wr_addr),
        .wr_data (upd_out),
        .rd_en   (bkt_rd_en),
        .rd_addr (idx_reg),
        .rd_data (bkt_rd_data)
    );

    // a freshly claimed bucket starts now with a zero count
    assign upd_in = (state_reg == S_UPDATE) ? bkt_rd_data
                                            : bucket_t'{window_start: now_reg, count: '0};

    pcrl_window_update u_update (
        .now_us           (now_reg),
        .window_length_us (window_reg),
        .limit            (limit_reg),
        .cur              (upd_in),
        .nxt              (upd_out),
        .allowed          (upd_allowed)
    );

    // key read data belongs to idx_reg while scanning; an empty table never matches
    assign match    = (used_reg != '0) && (key_rd_data == key_reg);
    assign next_pos = (CNT_W+1)'(idx_reg) + 1'b1;
    assign is_last  = next_pos >= (CNT_W+1)'(used_reg);
    assign all_used = (used_reg == CNT_W'(NUM_BUCKETS));
    assign bkt_wr_addr = (state_reg == S_UPDATE) ? idx_reg : IDX_W'(used_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        done_next    = 1'b0;
        allowed_next = allowed_reg;
        full_next    = full_reg;
        key_rd_en    = 1'b0;
        key_rd_addr  = '0;
        key_wr_en    = 1'b0;
        bkt_rd_en    = 1'b0;
        bkt_wr_en    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // fetch the first key
                    key_rd_en  = 1'b1;
                    idx_next   = '0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    // hit: fetch the bucket record for update
                    bkt_rd_en  = 1'b1;
                    state_next = S_UPDATE;
                end
                else if (!is_last)
                begin
                    key_rd_en   = 1'b1;
                    key_rd_addr = IDX_W'(next_pos);
                    idx_next    = IDX_W'(next_pos);
                end
                else if (all_used)
                begin
                    // unknown key with no free bucket passes unchecked
                    done_next    = 1'b1;
                    allowed_next = 1'b1;
                    full_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    // claim the next free bucket and count against it
                    key_wr_en    = 1'b1;
                    bkt_wr_en    = 1'b1;
                    used_next    = used_reg + 1'b1;
                    done_next    = 1'b1;
                    allowed_next = upd_allowed;
                    full_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                // write back the updated window and count
                bkt_wr_en    = 1'b1;
                done_next    = 1'b1;
                allowed_next = upd_allowed;
                full_next    = 1'b0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            used_reg    <= '0;
            window_reg  <= WINDOW_RESET_US;
            done_reg    <= 1'b0;
            allowed_reg <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            used_reg    <= used_next;
            done_reg    <= done_next;
            allowed_reg <= allowed_next;
            full_reg    <= full_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    // request fields held for the whole scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= category_key;
            limit_reg <= limit;
            now_reg   <= now_us;
        end
    end

endmodule

@@ sv/pcrl_ram.sv @@
// simple dual-port synchronous ram, one write port and one registered read port
module pcrl_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/pcrl_window_update.sv @@
// window restart and limit check for one bucket record
module pcrl_window_update
    import pcrl_pkg::*;
(
    input  logic [TIME_W-1:0]   now_us,
    input  logic [WINDOW_W-1:0] window_length_us,
    input  logic [LIMIT_W-1:0]  limit,
    input  bucket_t             cur,
    output bucket_t             nxt,
    output logic                allowed
);

    logic [TIME_W-1:0]  age;
    logic               elapsed;
    logic [LIMIT_W-1:0] base_count;

    always_comb
    begin
        age        = now_us - cur.window_start;
        // time running backwards never restarts the window
        elapsed    = (now_us >= cur.window_start) &&
                     (age >= {{(TIME_W-WINDOW_W){1'b0}}, window_length_us});
        base_count = elapsed ? '0 : cur.count;
        allowed    = base_count < limit;
        nxt.window_start = elapsed ? now_us : cur.window_start;
        nxt.count        = allowed ? base_count + 1'b1 : base_count;
    end

endmodule

@@ verif/per_category_rate_limiter_unit_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the per-category fixed-window rate limiter unit
module per_category_rate_limiter_unit_tb;
    import pcrl_pkg::*;

    localparam int NUM_BUCKETS  = NUM_BUCKETS_DEFAULT;
    // drain time after the last answer, sized from the longest request
    localparam int DRAIN_CYCLES = NUM_BUCKETS + 4;
    // cycles with neither an accepted request nor a result before giving up
    localparam int STALL_LIMIT  = 4000;

    localparam logic [KEY_W-1:0]    KEY_ALL_ONES   = '1;
    localparam logic [LIMIT_W-1:0]  LIMIT_MAX      = '1;
    localparam logic [TIME_W-1:0]   TIME_MAX       = '1;
    localparam logic [WINDOW_W-1:0] WINDOW_MAX     = '1;
    localparam logic [TIME_W-1:0]   FIRST_CLAIM_US = 48'd100;

    // expected outcome of one request, key kept for messages
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             allowed;
        logic             table_full;
    } verdict_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [WINDOW_W-1:0] cfg_wr_data  = '0;
    logic                start        = 1'b0;
    logic                busy;
    logic [KEY_W-1:0]    category_key = '0;
    logic [LIMIT_W-1:0]  limit        = '0;
    logic [TIME_W-1:0]   now_us       = '0;
    logic                done;
    logic                allowed;
    logic                table_full;

    // shadow copy of the bucket table and the window register
    logic [KEY_W-1:0]    slot_key   [NUM_BUCKETS];
    logic [TIME_W-1:0]   slot_start [NUM_BUCKETS];
    logic [LIMIT_W-1:0]  slot_count [NUM_BUCKETS];
    int                  slots_used = 0;
    logic [WINDOW_W-1:0] window_us  = WINDOW_RESET_US;

    verdict_t            pending_verdicts [$];
    int                  error_count  = 0;
    int                  stall_cycles = 0;
    bit                  idle_enable  = 1'b1;
    // running time base for well-formed traffic, never goes backwards
    logic [TIME_W-1:0]   clock_us     = '0;

    per_category_rate_limiter_unit #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .start        (start),
        .busy         (busy),
        .category_key (category_key),
        .limit        (limit),
        .now_us       (now_us),
        .done         (done),
        .allowed      (allowed),
        .table_full   (table_full)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor: updates the shadow table and returns the verdict
    // ------------------------------------------------------------------
    function automatic verdict_t rate_decide(input logic [KEY_W-1:0] key,
                                             input logic [LIMIT_W-1:0] lim,
                                             input logic [TIME_W-1:0] now);
        verdict_t v;
        int       slot;
        v.key        = key;
        v.allowed    = 1'b1;
        v.table_full = 1'b0;
        slot         = -1;
        // first matching bucket wins
        for (int i = 0; i < slots_used; i++)
        begin
            if (slot < 0 && slot_key[i] == key)
                slot = i;
        end
        if (slot < 0)
        begin
            // no match and no room: request passes unchecked
            if (slots_used >= NUM_BUCKETS)
            begin
                v.table_full = 1'b1;
                return v;
            end
            slot             = slots_used;
            slots_used       = slots_used + 1;
            slot_key[slot]   = key;
            slot_start[slot] = now;
            slot_count[slot] = '0;
        end
        // window restart only when time moved forward by at least the window
        if (now >= slot_start[slot] &&
            (now - slot_start[slot]) >= {{(TIME_W-WINDOW_W){1'b0}}, window_us})
        begin
            slot_count[slot] = '0;
            slot_start[slot] = now;
        end
        if (slot_count[slot] >= lim)
            v.allowed = 1'b0;
        else
            slot_count[slot] = slot_count[slot] + 1'b1;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // random sender gap: a quarter of the time an idle burst before the request, none when gaps are disabled
    function automatic int idle_gap();
        if (!idle_enable)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    // a key that no bucket holds yet
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] key;
        bit               known;
        do
        begin
            key   = $urandom();
            known = 1'b0;
            for (int i = 0; i < slots_used; i++)
            begin
                if (slot_key[i] == key)
                    known = 1'b1;
            end
        end
        while (known);
        return key;
    endfunction

    // half the time one of two hot buckets, so counts climb to the limit
    function automatic int pick_slot();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, (slots_used > 1) ? 1 : 0);
        return $urandom_range(0, slots_used - 1);
    endfunction

    // step the time base by a random amount up to a sixteenth of the current window (up to 2 below 32)
    function automatic void advance_clock();
        int unsigned span;
        span     = (window_us >= 32) ? window_us / 16 : 2;
        clock_us = clock_us + TIME_W'($urandom_range(0, span));
    endfunction

    // drive one request, hold it until accepted, then record its verdict
    // start is left high on return so back-to-back requests need no dip
    task automatic send_request(input logic [KEY_W-1:0] key,
                                input logic [LIMIT_W-1:0] lim,
                                input logic [TIME_W-1:0] now);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        category_key <= key;
        limit        <= lim;
        now_us       <= now;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_verdicts.push_back(rate_decide(key, lim, now));
    endtask

    // lower start and wait until every outstanding request has answered
    task automatic wait_idle();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_verdicts.size() != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // single register, only written while the unit is idle
    task automatic write_window(input logic [WINDOW_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_us    = value;
    endtask

    // one random request; assumes the table is already full
    task automatic random_request();
        int                 pick;
        int                 s;
        int                 back;
        logic [63:0]        rnd;
        logic [TIME_W-1:0]  now;
        logic [LIMIT_W-1:0] lim;
        pick = $urandom_range(0, 99);
        lim  = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom())
                                           : LIMIT_W'($urandom_range(0, 4));
        if (pick < 12)
        begin
            // unknown key: full-flag path, any time value, table untouched
            rnd = {$urandom(), $urandom()};
            send_request(fresh_key(), LIMIT_W'($urandom()), rnd[TIME_W-1:0]);
        end
        else
        begin
            s = pick_slot();
            if (pick < 20 && slot_start[s] != '0)
            begin
                // time going backwards relative to the bucket's window start
                back = (slot_start[s] > 1000) ? 1000 : int'(slot_start[s]);
                now  = slot_start[s] - TIME_W'($urandom_range(1, back));
            end
            else
            begin
                advance_clock();
                now = clock_us;
            end
            send_request(slot_key[s], lim, now);
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] key,
                                   input logic got, input logic want);
        $display("[%0t] mismatch: %s key=%08h got=%0b want=%0b", $realtime, what, key,
                 got, want);
        error_count = error_count + 1;
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("result with no request pending", category_key, allowed,
                                1'b0);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (allowed !== want.allowed)
                    report_mismatch("allowed", want.key, allowed, want.allowed);
                if (table_full !== want.table_full)
                    report_mismatch("table_full", want.key, table_full, want.table_full);
            end
        end
    end

    // watchdog: nothing accepted and no result for too long means the unit hung
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles + 1 >= STALL_LIMIT)
        begin
            $display("per_category_rate_limiter_unit_tb: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // claim, limit, backwards time, exact window edge, table fill, full flag
    task automatic test_directed_buckets();
        // zero limit refuses even a freshly claimed bucket
        send_request('0, '0, FIRST_CLAIM_US);
        send_request('0, 16'd2, FIRST_CLAIM_US + 10);
        send_request('0, 16'd2, FIRST_CLAIM_US + 20);
        // count at the limit: refused
        send_request('0, 16'd2, FIRST_CLAIM_US + 30);
        // time before the window start: no restart, still refused
        send_request('0, 16'd2, '0);
        // exactly one window later: restart, allowed again
        send_request('0, 16'd2, FIRST_CLAIM_US + TIME_W'(WINDOW_RESET_US));
        clock_us = FIRST_CLAIM_US + TIME_W'(WINDOW_RESET_US);
        send_request(KEY_ALL_ONES, LIMIT_MAX, clock_us);
        send_request(KEY_ALL_ONES, LIMIT_MAX, clock_us - 1);
        // fill the rest of the table
        while (slots_used < NUM_BUCKETS)
        begin
            advance_clock();
            send_request(fresh_key(), LIMIT_W'($urandom_range(0, 3)), clock_us);
        end
        // table full: unknown keys pass with the flag, at both time extremes
        send_request(fresh_key(), '0, TIME_MAX);
        send_request(fresh_key(), LIMIT_MAX, '0);
        advance_clock();
        send_request('0, 16'd1, clock_us);
    endtask

    // zero, one and maximum window, then back to the reset value
    task automatic test_window_extremes();
        wait_idle();
        write_window('0);
        // zero window: every request restarts the window
        send_request('0, 16'd1, clock_us);
        send_request('0, 16'd1, clock_us);
        send_request('0, 16'd1, clock_us);
        // but not when time runs backwards
        send_request('0, 16'd1, clock_us - 1);
        wait_idle();
        write_window(WINDOW_MAX);
        clock_us = clock_us + 48'd1000000000;
        send_request(KEY_ALL_ONES, 16'd3, clock_us);
        send_request(KEY_ALL_ONES, 16'd3, clock_us);
        wait_idle();
        write_window(32'd1);
        send_request(slot_key[2], 16'd1, clock_us);
        send_request(slot_key[2], 16'd1, clock_us);
        send_request(slot_key[2], 16'd1, clock_us + 1);
        wait_idle();
        write_window(WINDOW_RESET_US);
    endtask

    // phases of random traffic, each under its own window setting
    task automatic test_random_traffic();
        logic [WINDOW_W-1:0] windows [6];
        windows[0] = WINDOW_RESET_US;
        windows[1] = '0;
        windows[2] = 32'd1;
        windows[3] = WINDOW_MAX;
        windows[4] = WINDOW_W'($urandom_range(2, 64));
        windows[5] = WINDOW_W'($urandom());
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            write_window(windows[ph]);
            // every third phase runs without sender gaps
            idle_enable = (ph % 3 != 2);
            for (int n = 0; n < 100; n++)
            begin
                // hold off until all answers are in, mid-phase
                if (ph == 1 && n == 50)
                    wait_idle();
                random_request();
            end
        end
        idle_enable = 1'b1;
    endtask

    // closing stretch: back-to-back requests, no sender gaps
    task automatic test_back_to_back();
        wait_idle();
        write_window(WINDOW_W'($urandom_range(40, 200)));
        idle_enable = 1'b0;
        for (int n = 0; n < 40; n++)
            random_request();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_buckets();
        test_window_extremes();
        test_random_traffic();
        test_back_to_back();
        wait_idle();
        if (error_count == 0)
            $display("per_category_rate_limiter_unit_tb: done, clean");
        else
            $display("per_category_rate_limiter_unit_tb: done, errors");
        $finish;
    end

endmodule
